// ===== design/lbd_pkg.sv =====
// ============================================================================
// lbd_pkg - shared types and constants for the loud burst detector
// Payload structs, configuration register map and reset values.
// ============================================================================
`default_nettype none

package lbd_pkg;

    // Register file address width: four 32-bit registers at 4-byte spacing
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Reset values of the configuration registers
    localparam logic [11:0] THRESHOLD_RST = 12'd2100;
    localparam logic [31:0] SPAN_RST      = 32'd10000;
    localparam logic [31:0] SILENCE_RST   = 32'd5000;
    localparam logic [31:0] COOLDOWN_RST  = 32'd15000;

    // Register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_LEVEL_THRESHOLD = 2'd0,
        REG_SPAN_MS         = 2'd1,
        REG_SILENCE_MS      = 2'd2,
        REG_COOLDOWN_MS     = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [11:0] level_threshold;
        logic [31:0] span_ms;
        logic [31:0] silence_ms;
        logic [31:0] cooldown_ms;
    } cfg_t;

    typedef struct packed {
        logic [11:0] sample;
        logic [31:0] time_ms;
    } sample_t;

    typedef struct packed {
        logic       alert;
        logic       is_peak;
        logic [3:0] peaks_held;
    } result_t;

endpackage

`default_nettype wire

// ===== design/loud_burst_detector.sv =====
// ============================================================================
// loud_burst_detector - peak counter with burst alert
// Counts samples above a threshold, keeps the times of the last N peaks and
// alerts when N peaks fall inside the window outside the cooldown.
// ============================================================================
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+---------------------
//  sample   | in        | sample_valid / sample_stall  | sample_data (sample_t)
//  result   | out       | result_valid / result_stall  | result_data (result_t)
//  config   | in        | APB psel/penable/pwrite      | paddr, pwdata, prdata
//
//  One transaction per clock sustained while result_stall is low. A sample taken
//  at an edge is held in the input register, and its result is then loaded into
//  the result register, which drives result_valid.
//  The step logic (three 32-bit wrapped differences and compares, one ring
//  write) sits between the input register and the result register.
//  Reset clears the configuration to defaults and the ring, slot, tally and
//  time registers to zero; no clearing pass is needed.
//  result_stall holds the result register; the input register then fills and
//  sample_stall rises only once both stages are occupied.
//
`default_nettype none

module loud_burst_detector #(
    parameter int PEAKS_NEEDED = 5   // 1..8
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // sample channel
    input  wire logic                       sample_valid,
    output logic                            sample_stall,
    input  wire lbd_pkg::sample_t           sample_data,
    // result channel
    output logic                            result_valid,
    input  wire logic                       result_stall,
    output lbd_pkg::result_t                result_data,
    // configuration
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [lbd_pkg::ADDR_W-1:0] paddr,
    input  wire logic [lbd_pkg::DATA_W-1:0] pwdata,
    output logic      [lbd_pkg::DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int          SLOT_W     = (PEAKS_NEEDED > 1) ? $clog2(PEAKS_NEEDED) : 1;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(PEAKS_NEEDED - 1);
    localparam logic [3:0]  TALLY_FULL = 4'(PEAKS_NEEDED);

    lbd_pkg::cfg_t cfg;

    lbd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    // ------------------------------------------------------------------
    // Handshake: input register -> step logic -> result register
    // ------------------------------------------------------------------
    logic             in_valid_reg, in_valid_next;
    lbd_pkg::sample_t in_reg, in_next;
    logic             res_valid_reg, res_valid_next;
    lbd_pkg::result_t res_reg, res_next;

    logic out_busy;   // result register holds a transaction that is not taken
    logic step_en;    // the input register's transaction is processed now

    assign out_busy     = res_valid_reg && result_stall;
    assign sample_stall = in_valid_reg && out_busy;
    assign step_en      = in_valid_reg && !out_busy;

    // ------------------------------------------------------------------
    // Detector state
    // ------------------------------------------------------------------
    logic [31:0]       ring_reg [PEAKS_NEEDED];
    logic [31:0]       ring_next [PEAKS_NEEDED];
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [3:0]        tally_reg, tally_next;
    logic [31:0]       last_peak_reg, last_peak_next;
    logic [31:0]       last_alert_reg, last_alert_next;

    // Step logic
    logic [31:0]       now;
    logic              peak;
    logic [SLOT_W-1:0] slot_adv;
    logic [3:0]        tally_inc;
    logic [31:0]       oldest;
    logic              in_window;
    logic              cooled;
    logic              quiet_long;
    logic              alert;

    always_comb
    begin
        now      = in_reg.time_ms;
        peak     = in_reg.sample > cfg.level_threshold;
        slot_adv = (slot_reg == SLOT_LAST) ? '0 : slot_reg + SLOT_W'(1);
        tally_inc = (tally_reg < TALLY_FULL) ? tally_reg + 4'd1 : tally_reg;

        // Oldest peak is the slot the next peak will overwrite; with a single
        // slot that is the entry written by this very peak.
        oldest     = (slot_adv == slot_reg) ? now : ring_reg[slot_adv];
        in_window  = (now - oldest) <= cfg.span_ms;
        cooled     = (now - last_alert_reg) > cfg.cooldown_ms;
        quiet_long = (now - last_peak_reg) > cfg.silence_ms;
        alert      = peak && (tally_inc == TALLY_FULL) && in_window && cooled;

        ring_next       = ring_reg;
        slot_next       = slot_reg;
        tally_next      = tally_reg;
        last_peak_next  = last_peak_reg;
        last_alert_next = last_alert_reg;

        if (step_en)
        begin
            if (peak)
            begin
                ring_next[slot_reg] = now;
                slot_next           = slot_adv;
                last_peak_next      = now;
                tally_next          = alert ? 4'd0 : tally_inc;
                if (alert)
                begin
                    last_alert_next = now;
                end
            end
            else if ((tally_reg != 4'd0) && quiet_long)
            begin
                tally_next = 4'd0;
            end
        end
    end

    // Handshake next state
    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_next       = in_reg;
        if (!sample_stall)
        begin
            in_valid_next = sample_valid;
            in_next       = sample_data;
        end

        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (!out_busy)
        begin
            res_valid_next = in_valid_reg;
            if (in_valid_reg)
            begin
                res_next.alert      = alert;
                res_next.is_peak    = peak;
                res_next.peaks_held = tally_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
            slot_reg       <= '0;
            tally_reg      <= 4'd0;
            last_peak_reg  <= 32'd0;
            last_alert_reg <= 32'd0;
            for (int i = 0; i < PEAKS_NEEDED; i++)
            begin
                ring_reg[i] <= 32'd0;
            end
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            res_valid_reg  <= res_valid_next;
            slot_reg       <= slot_next;
            tally_reg      <= tally_next;
            last_peak_reg  <= last_peak_next;
            last_alert_reg <= last_alert_next;
            ring_reg       <= ring_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        in_reg  <= in_next;
        res_reg <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result_data  = res_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_alert_needs_peak: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.alert |-> result_data.is_peak)
        else $error("alert without a peak");

    a_alert_clears_tally: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.alert |-> result_data.peaks_held == 4'd0)
        else $error("alert left a non-zero tally");

    a_tally_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        tally_reg <= TALLY_FULL)
        else $error("tally above peak count");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> in_valid_reg && result_valid && result_stall)
        else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

// ===== design/lbd_regs.sv =====
// ============================================================================
// lbd_regs - APB configuration register file
// Four registers, written on the access phase, read back zero-extended.
// ============================================================================
`default_nettype none

module lbd_regs (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [lbd_pkg::ADDR_W-1:0] paddr,
    input  wire logic [lbd_pkg::DATA_W-1:0] pwdata,
    output logic      [lbd_pkg::DATA_W-1:0] prdata,
    output lbd_pkg::cfg_t                  cfg
);

    lbd_pkg::cfg_t    cfg_reg;
    lbd_pkg::cfg_t    cfg_next;
    lbd_pkg::reg_idx_t idx;
    logic             wr_en;

    assign idx   = lbd_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                lbd_pkg::REG_LEVEL_THRESHOLD: cfg_next.level_threshold = pwdata[11:0];
                lbd_pkg::REG_SPAN_MS:         cfg_next.span_ms         = pwdata;
                lbd_pkg::REG_SILENCE_MS:      cfg_next.silence_ms      = pwdata;
                lbd_pkg::REG_COOLDOWN_MS:     cfg_next.cooldown_ms     = pwdata;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.level_threshold <= lbd_pkg::THRESHOLD_RST;
            cfg_reg.span_ms         <= lbd_pkg::SPAN_RST;
            cfg_reg.silence_ms      <= lbd_pkg::SILENCE_RST;
            cfg_reg.cooldown_ms     <= lbd_pkg::COOLDOWN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            lbd_pkg::REG_LEVEL_THRESHOLD: prdata = {20'd0, cfg_reg.level_threshold};
            lbd_pkg::REG_SPAN_MS:         prdata = cfg_reg.span_ms;
            lbd_pkg::REG_SILENCE_MS:      prdata = cfg_reg.silence_ms;
            lbd_pkg::REG_COOLDOWN_MS:     prdata = cfg_reg.cooldown_ms;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== tb/loud_burst_detector_tb.sv =====
// ============================================================================
// loud_burst_detector_tb - self-checking bench for the loud burst detector
// Drives sample transactions through a directed table and then through random
// bursts, quiet runs and noise under several register settings. It checks each
// result against a typed row's value or a cycle-free model of the peak tally,
// the peak time ring and alert cooldown. Both channels idle and stall at random.
// ============================================================================

module loud_burst_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Burst length; must match the parameter given to the block below
    localparam int BURST_LEN = 5;
    localparam int PHASE_ITEMS = 180;
    localparam int NUM_PHASES = 6;
    localparam int NUM_ROWS = 21;

    // One row of the directed table. Rows with typed set carry a hand-derived
    // result; all other rows take their expected result from the model below.
    typedef struct packed {
        bit          typed;
        bit          want_alert;
        bit          want_peak;
        logic [3:0]  want_held;
        logic [11:0] sample;
        logic [31:0] time_ms;
    } dir_row_t;

    // Register defaults: threshold 2100, window 10000, silence 5000,
    // cooldown 15000.
    localparam dir_row_t DIRECTED_ROWS [0:NUM_ROWS-1] = '{
        // quiet sample after reset, then a sample equal to the threshold
        '{1'b1, 1'b0, 1'b0, 4'd0, 12'd0,    32'd0},
        '{1'b1, 1'b0, 1'b0, 4'd0, 12'd2100, 32'd10},
        // one above the threshold and full scale both count as peaks
        '{1'b1, 1'b0, 1'b1, 4'd1, 12'd2101, 32'd20},
        '{1'b1, 1'b0, 1'b1, 4'd2, 12'd4095, 32'd30},
        // quiet: exactly silence_ms after the last peak keeps the tally,
        // one more millisecond clears it
        '{1'b1, 1'b0, 1'b0, 4'd2, 12'd0,    32'd40},
        '{1'b1, 1'b0, 1'b0, 4'd2, 12'd0,    32'd5030},
        '{1'b1, 1'b0, 1'b0, 4'd0, 12'd0,    32'd5031},
        // first alert after reset: only once time is past the cooldown
        '{1'b1, 1'b0, 1'b1, 4'd1, 12'd4095, 32'd16000},
        '{1'b1, 1'b0, 1'b1, 4'd2, 12'd4095, 32'd16001},
        '{1'b1, 1'b0, 1'b1, 4'd3, 12'd4095, 32'd16002},
        '{1'b1, 1'b0, 1'b1, 4'd4, 12'd4095, 32'd16003},
        '{1'b1, 1'b1, 1'b1, 4'd0, 12'd4095, 32'd16004},
        // a second full burst right away is blocked by the cooldown
        '{1'b0, 1'b0, 1'b0, 4'd0, 12'd3000, 32'd16005},
        '{1'b0, 1'b0, 1'b0, 4'd0, 12'd3000, 32'd16006},
        '{1'b0, 1'b0, 1'b0, 4'd0, 12'd3000, 32'd16007},
        '{1'b0, 1'b0, 1'b0, 4'd0, 12'd3000, 32'd16008},
        '{1'b1, 1'b0, 1'b1, 4'd5, 12'd3000, 32'd16009},
        // time going backwards and wrapping
        '{1'b0, 1'b0, 1'b0, 4'd0, 12'd4095, 32'd5},
        '{1'b0, 1'b0, 1'b0, 4'd0, 12'd4095, 32'hFFFF_FFFF},
        '{1'b0, 1'b0, 1'b0, 4'd0, 12'd0,    32'hFFFF_FFFF},
        '{1'b0, 1'b0, 1'b0, 4'd0, 12'd0,    32'h7FFF_FFFF}
    };

    logic                           clk;
    logic                           rst_n;
    logic                           sample_valid;
    logic                           sample_stall;
    lbd_pkg::sample_t               sample_data;
    logic                           result_valid;
    logic                           result_stall;
    lbd_pkg::result_t               result_data;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [lbd_pkg::ADDR_W-1:0]     paddr;
    logic [lbd_pkg::DATA_W-1:0]     pwdata;
    logic [lbd_pkg::DATA_W-1:0]     prdata;
    logic                           pready;

    loud_burst_detector #(
        .PEAKS_NEEDED (BURST_LEN)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_data  (sample_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // ------------------------------------------------------------------------
    // Model state: register copy plus the detector's own state
    // ------------------------------------------------------------------------
    lbd_pkg::cfg_t model_cfg;
    logic [31:0]   peak_ring [BURST_LEN];
    logic [2:0]    ring_slot;
    logic [3:0]    tally;
    logic [31:0]   last_peak;
    logic [31:0]   last_alert;

    lbd_pkg::result_t pending_results [$];
    int            mismatch_count;

    // Sender and receiver idle bookkeeping
    int            sender_calm;
    int            stall_hold;
    bit            stall_level;

    // Running timestamp for the random part; wraps at 2^32 like the block's
    logic [31:0]   now_ms;

    // 12 ns clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Model of one step: takes a sample, updates the state, returns the result
    // ------------------------------------------------------------------------
    function automatic lbd_pkg::result_t detect_burst(input lbd_pkg::sample_t item);
        lbd_pkg::result_t res;
        logic [31:0]      oldest;
        res = '0;
        res.is_peak = (item.sample > model_cfg.level_threshold);
        if (res.is_peak)
        begin
            last_peak = item.time_ms;
            peak_ring[ring_slot] = item.time_ms;
            ring_slot = (ring_slot == 3'(BURST_LEN - 1)) ? 3'd0 : ring_slot + 3'd1;
            if (tally < 4'(BURST_LEN))
                tally = tally + 4'd1;
            // With a full tally the slot about to be overwritten is the oldest
            if (tally == 4'(BURST_LEN))
            begin
                oldest = peak_ring[ring_slot];
                if (32'(item.time_ms - oldest) <= model_cfg.span_ms &&
                    32'(item.time_ms - last_alert) > model_cfg.cooldown_ms)
                begin
                    res.alert = 1'b1;
                    last_alert = item.time_ms;
                    tally = 4'd0;
                end
            end
        end
        else if (tally != 4'd0 && 32'(item.time_ms - last_peak) > model_cfg.silence_ms)
        begin
            tally = 4'd0;
        end
        res.peaks_held = tally;
        return res;
    endfunction

    // Sender gaps: mostly none or short, now and then long, plus calm stretches
    function automatic int sender_gap();
        int r;
        if (sender_calm > 0)
        begin
            sender_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            sender_calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    // Time advance between samples, from zero up to a full wrap
    function automatic logic [31:0] time_step(input bit tight);
        int r;
        r = $urandom_range(0, 99);
        if (tight)
            return (r < 80) ? $urandom_range(0, 40) : $urandom_range(0, 3000);
        if (r < 40)
            return $urandom_range(0, 40);
        if (r < 70)
            return $urandom_range(0, 3000);
        if (r < 95)
            return $urandom_range(0, 60000);
        return $urandom;
    endfunction

    // Loud level: strictly above threshold where possible, often right at the edge
    function automatic logic [11:0] loud_level();
        if (model_cfg.level_threshold == 12'hFFF)
            return 12'hFFF;
        if ($urandom_range(0, 4) == 0)
            return model_cfg.level_threshold + 12'd1;
        return 12'($urandom_range(int'(model_cfg.level_threshold) + 1, 4095));
    endfunction

    // Quiet level: at or below threshold, often exactly at it
    function automatic logic [11:0] quiet_level();
        if ($urandom_range(0, 4) == 0)
            return model_cfg.level_threshold;
        return 12'($urandom_range(0, int'(model_cfg.level_threshold)));
    endfunction

    // ------------------------------------------------------------------------
    // Sample channel: called at a clock edge, returns at the edge where the
    // transaction was taken. valid stays high after acceptance; the caller
    // either presents the next sample or drops valid in that same step.
    // ------------------------------------------------------------------------
    task automatic push_sample(input lbd_pkg::sample_t item, input bit typed,
                               input lbd_pkg::result_t want);
        int               gap;
        lbd_pkg::result_t predicted;
        gap = sender_gap();
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_data  <= item;
        do
            @(posedge clk);
        while (!(sample_valid && !sample_stall));
        // Model always advances; directed rows with a typed result use that
        predicted = detect_burst(item);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic push_random(input logic [11:0] level, input logic [31:0] step);
        lbd_pkg::sample_t item;
        now_ms = now_ms + step;
        item.sample  = level;
        item.time_ms = now_ms;
        push_sample(item, 1'b0, '0);
    endtask

    // Drop valid and wait for the pipeline to drain before touching registers
    task automatic wait_idle();
        sample_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write: setup cycle, access cycle, register written at the edge
    // where psel, penable, pwrite and pready are all high
    task automatic write_reg(input lbd_pkg::reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            lbd_pkg::REG_LEVEL_THRESHOLD: model_cfg.level_threshold = value[11:0];
            lbd_pkg::REG_SPAN_MS:         model_cfg.span_ms = value;
            lbd_pkg::REG_SILENCE_MS:      model_cfg.silence_ms = value;
            lbd_pkg::REG_COOLDOWN_MS:     model_cfg.cooldown_ms = value;
            default:                      ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Register settings per phase: defaults, both extremes, a tight scale
    // where alerts fire often, a random one and a mixed corner
    function automatic lbd_pkg::cfg_t phase_setting(input int phase);
        lbd_pkg::cfg_t c;
        case (phase)
            0: c = '{lbd_pkg::THRESHOLD_RST, lbd_pkg::SPAN_RST, lbd_pkg::SILENCE_RST,
                     lbd_pkg::COOLDOWN_RST};
            1: c = '{12'd0, 32'd0, 32'd0, 32'd0};
            2: c = '{12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
            3: c = '{12'd1000, 32'd300, 32'd50, 32'd500};
            4: c = '{12'($urandom_range(0, 4095)), 32'($urandom_range(0, 20000)),
                     32'($urandom_range(0, 8000)), 32'($urandom_range(0, 30000))};
            default: c = '{12'd3000, 32'hFFFF_FFFF, 32'd0, 32'd0};
        endcase
        return c;
    endfunction

    // Mix of well-formed bursts, quiet runs and raw noise
    task automatic run_phase(input int n_items);
        int count;
        int pick;
        int len;
        count = 0;
        while (count < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                // burst: at least a full tally of samples close together, mostly loud,
                // with a few quiet ones mixed in
                push_random(loud_level(), time_step(1'b0));
                len = $urandom_range(BURST_LEN, BURST_LEN + 3);
                for (int k = 1; k < len; k++)
                begin
                    if ($urandom_range(0, 99) < 12)
                        push_random(quiet_level(), time_step(1'b1));
                    else
                        push_random(loud_level(), time_step(1'b1));
                end
                count += len;
            end
            else if (pick < 85)
            begin
                len = $urandom_range(1, 5);
                for (int k = 0; k < len; k++)
                    push_random(quiet_level(), time_step(1'b0));
                count += len;
            end
            else
            begin
                // noise: any sample at any time, so every bit toggles
                len = $urandom_range(1, 3);
                for (int k = 0; k < len; k++)
                    push_random(12'($urandom_range(0, 4095)), $urandom);
                count += len;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result channel: random stall runs and calm stretches, checks every
    // accepted transaction against the oldest expectation
    // ------------------------------------------------------------------------
    task automatic report_field(input string name, input int want, input int got);
        mismatch_count++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $realtime, name,
                 want, got);
    endtask

    initial
    begin
        lbd_pkg::result_t want;
        result_stall = 1'b0;
        stall_hold = 0;
        stall_level = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t ns: unexpected result, expected none, actual %p",
                             $realtime, result_data);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result_data.alert !== want.alert)
                        report_field("alert", want.alert, result_data.alert);
                    if (result_data.is_peak !== want.is_peak)
                        report_field("is_peak", want.is_peak, result_data.is_peak);
                    if (result_data.peaks_held !== want.peaks_held)
                        report_field("peaks_held", want.peaks_held, result_data.peaks_held);
                end
            end
            if (stall_hold > 0)
            begin
                stall_hold--;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3:
                    begin
                        stall_level = 1'b0;
                        stall_hold = $urandom_range(0, 40);
                    end
                    4, 5, 6, 7, 8:
                    begin
                        stall_level = 1'b1;
                        stall_hold = $urandom_range(0, 2);
                    end
                    default:
                    begin
                        stall_level = 1'b1;
                        stall_hold = $urandom_range(7, 23);
                    end
                endcase
            end
            result_stall <= stall_level;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        lbd_pkg::sample_t item;
        lbd_pkg::result_t want;
        lbd_pkg::cfg_t    setting;
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample_data  = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        mismatch_count = 0;
        sender_calm  = 0;
        now_ms       = '0;

        // Model reset mirrors the block's reset
        model_cfg  = '{lbd_pkg::THRESHOLD_RST, lbd_pkg::SPAN_RST, lbd_pkg::SILENCE_RST,
                       lbd_pkg::COOLDOWN_RST};
        for (int k = 0; k < BURST_LEN; k++)
            peak_ring[k] = '0;
        ring_slot  = '0;
        tally      = '0;
        last_peak  = '0;
        last_alert = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, run on reset defaults
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            item.sample     = DIRECTED_ROWS[r].sample;
            item.time_ms    = DIRECTED_ROWS[r].time_ms;
            want.alert      = DIRECTED_ROWS[r].want_alert;
            want.is_peak    = DIRECTED_ROWS[r].want_peak;
            want.peaks_held = DIRECTED_ROWS[r].want_held;
            push_sample(item, DIRECTED_ROWS[r].typed, want);
        end
        now_ms = DIRECTED_ROWS[NUM_ROWS-1].time_ms;

        // Random phases, registers rewritten only with the pipeline drained
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            setting = phase_setting(p);
            write_reg(lbd_pkg::REG_LEVEL_THRESHOLD, {20'd0, setting.level_threshold});
            write_reg(lbd_pkg::REG_SPAN_MS, setting.span_ms);
            write_reg(lbd_pkg::REG_SILENCE_MS, setting.silence_ms);
            write_reg(lbd_pkg::REG_COOLDOWN_MS, setting.cooldown_ms);
            run_phase(PHASE_ITEMS);
        end

        // Drain and let the pipeline settle before the verdict
        wait_idle();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
